[rtl/core/pbp_pkg.sv]
package pbp_pkg;

  // Fixed field widths
  localparam int ADDR_W    = 32;
  localparam int ROW_SHIFT = 3;
  localparam int SUM_OUT_W = 14;
  localparam int THR_W     = 10;

  // Weights held in one memory word
  localparam int LANES = 8;

  // Row index reduction: quotient by reciprocal multiply, then remainder
  localparam int REDUCE_STEPS = 2;

  // Request codes
  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_UPDATE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SUM,
    ST_DECIDE,
    ST_TRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic reduce;
    logic sum_pass;
    logic decide;
    logic train_pass;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic reduce_last;
    logic pass_last;
    logic train_now;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/pbp_ram.sv]
module pbp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/pbp_ctrl.sv]
module pbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbp_pkg::dp_stat_t stat,
  output pbp_pkg::dp_cmd_t  cmd
);

  pbp_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pbp_pkg::ST_IDLE: begin
        if (in_valid) state_next = pbp_pkg::ST_REDUCE;
      end
      pbp_pkg::ST_REDUCE: begin
        if (stat.reduce_last) state_next = pbp_pkg::ST_SUM;
      end
      pbp_pkg::ST_SUM: begin
        if (stat.pass_last) state_next = pbp_pkg::ST_DECIDE;
      end
      pbp_pkg::ST_DECIDE: begin
        state_next = stat.train_now ? pbp_pkg::ST_TRAIN : pbp_pkg::ST_FINISH;
      end
      pbp_pkg::ST_TRAIN: begin
        if (stat.pass_last) state_next = pbp_pkg::ST_FINISH;
      end
      pbp_pkg::ST_FINISH: begin
        if (stat.out_free) state_next = pbp_pkg::ST_IDLE;
      end
      default: state_next = pbp_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      pbp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pbp_pkg::ST_REDUCE: cmd.reduce     = 1'b1;
      pbp_pkg::ST_SUM:    cmd.sum_pass   = 1'b1;
      pbp_pkg::ST_DECIDE: cmd.decide     = 1'b1;
      pbp_pkg::ST_TRAIN:  cmd.train_pass = 1'b1;
      pbp_pkg::ST_FINISH: cmd.finish     = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/core/pbp_dp.sv]
module pbp_dp #(
  parameter int GHR_BITS        = 32,
  parameter int NUM_PERCEPTRONS = 64,
  parameter int WEIGHT_BITS     = 8,
  parameter logic [pbp_pkg::THR_W-1:0] THR_RESET = 10'd75
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pbp_pkg::dp_cmd_t                    cmd,
  output pbp_pkg::dp_stat_t                   stat,
  input  logic                                req_type,
  input  logic [pbp_pkg::ADDR_W-1:0]          pc,
  input  logic                                taken,
  input  logic                                cfg_we,
  input  logic [pbp_pkg::THR_W-1:0]           cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                predict_taken,
  output logic signed [pbp_pkg::SUM_OUT_W-1:0] perceptron_sum,
  output logic                                trained
);

  localparam int LANES    = pbp_pkg::LANES;
  localparam int WPR      = (GHR_BITS + LANES - 1) / LANES;
  localparam int KW       = WPR > 1 ? $clog2(WPR) : 1;
  localparam int RW       = NUM_PERCEPTRONS > 1 ? $clog2(NUM_PERCEPTRONS) : 1;
  localparam int WORD_W   = LANES * WEIGHT_BITS;
  localparam int MEM_AW   = RW + KW;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam int BIAS_DEPTH = 1 << RW;
  localparam int SW       = WEIGHT_BITS + $clog2(GHR_BITS + 1) + 1;
  localparam int EW       = SW + pbp_pkg::SUM_OUT_W;
  localparam int PAD_W    = WPR * LANES;
  localparam int CNT_MAX  = WPR > pbp_pkg::REDUCE_STEPS ? WPR : pbp_pkg::REDUCE_STEPS;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS - 1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS - 1){1'b0}}};

  // Exact quotient of an XW-bit value by the row count: multiply by a rounded-up
  // reciprocal and drop XW+LG bits
  localparam int XW = pbp_pkg::ADDR_W - pbp_pkg::ROW_SHIFT;
  localparam int LG = $clog2(NUM_PERCEPTRONS);
  localparam int MW = XW + 1;
  localparam int PW = XW + MW;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << (XW + LG)) + 64'(NUM_PERCEPTRONS) - 64'd1) / 64'(NUM_PERCEPTRONS);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);
  localparam logic [XW-1:0] N_X   = XW'(NUM_PERCEPTRONS);

  // Item registers
  logic                          req_q;
  logic [pbp_pkg::ADDR_W-1:0]    addr_q;
  logic                          taken_q;
  logic [RW-1:0]                 row, row_next;
  logic [XW-1:0]                 quot, quot_next;
  logic [CNT_W-1:0]              cnt;
  logic signed [SW-1:0]          acc;
  logic signed [WEIGHT_BITS-1:0] bias_q;
  logic                          train_q;
  logic                          pred_q;
  logic [GHR_BITS-1:0]           hist;
  logic [pbp_pkg::THR_W-1:0]     thr;
  logic [NUM_PERCEPTRONS-1:0]    row_valid;

  // Memory ports
  logic              mem_re, mem_we;
  logic [MEM_AW-1:0] mem_raddr, mem_waddr;
  logic [WORD_W-1:0] mem_rdata, mem_wdata;
  logic              bias_re, bias_we;
  logic [WEIGHT_BITS-1:0] bias_rdata, bias_wdata;

  // Working signals
  logic [XW-1:0]                xs;
  logic [PW-1:0]                prod;
  logic [XW-1:0]                quot_n;
  logic [XW-1:0]                rem_x;
  logic [KW-1:0]                rd_k, wr_k;
  logic [WORD_W-1:0]            dw;
  logic signed [WEIGHT_BITS-1:0] bias_val;
  logic [PAD_W-1:0]             hist_pad;
  logic [LANES-1:0]             xb;
  logic [LANES-1:0]             lane_on;
  logic signed [SW-1:0]         word_sum;
  logic signed [EW-1:0]         acc_ext;
  logic signed [EW-1:0]         thr_ext;
  logic                         in_band;
  logic                         pred_now;
  logic                         cnt_pass_last;

  pbp_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_weight_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  pbp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(BIAS_DEPTH)) u_bias_ram (
    .clk  (clk),
    .we   (bias_we),
    .waddr(row),
    .wdata(bias_wdata),
    .re   (bias_re),
    .raddr(row),
    .rdata(bias_rdata)
  );

  // Row index: quotient in the first step, remainder in the second
  assign xs        = addr_q[pbp_pkg::ADDR_W-1:pbp_pkg::ROW_SHIFT];
  assign prod      = PW'(xs) * PW'(RECIP);
  assign quot_next = XW'(prod >> (XW + LG));
  assign quot_n    = quot * N_X;
  assign rem_x     = xs - quot_n;
  assign row_next  = RW'(rem_x);

  // Word addressing: issue word cnt, process the word read in the previous cycle
  assign rd_k          = KW'(cnt);
  assign wr_k          = KW'(cnt - CNT_W'(1));
  assign cnt_pass_last = (cnt == CNT_W'(WPR));
  assign mem_re        = (cmd.sum_pass || cmd.train_pass) && (cnt < CNT_W'(WPR));
  assign mem_raddr     = {row, rd_k};
  assign mem_waddr     = {row, wr_k};
  assign mem_we        = cmd.train_pass && (cnt != '0);
  assign bias_re       = cmd.sum_pass && (cnt == '0);
  assign bias_we       = cmd.train_pass && (cnt == '0);

  // Rows never trained read as zero
  assign dw       = row_valid[row] ? mem_rdata : '0;
  assign bias_val = row_valid[row] ? signed'(bias_rdata) : '0;

  // History bits that line up with the returning word
  assign hist_pad = PAD_W'(hist);
  assign xb       = hist_pad[LANES * int'(wr_k) +: LANES];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      lane_on[j] = (int'(wr_k) * LANES + j) < GHR_BITS;
    end
  end

  // Dot product of one word with the +1/-1 history
  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w;
    logic signed [SW-1:0] term;
    word_sum = '0;
    for (int j = 0; j < LANES; j++) begin
      w    = signed'(dw[j * WEIGHT_BITS +: WEIGHT_BITS]);
      term = xb[j] ? SW'(w) : -SW'(w);
      if (lane_on[j]) word_sum = word_sum + term;
    end
  end

  // Trained word: move each weight one step toward agreement, saturate
  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w;
    logic up;
    for (int j = 0; j < LANES; j++) begin
      w  = signed'(dw[j * WEIGHT_BITS +: WEIGHT_BITS]);
      up = (taken_q == xb[j]);
      if (!lane_on[j]) begin
        mem_wdata[j * WEIGHT_BITS +: WEIGHT_BITS] = w;
      end else if (up) begin
        mem_wdata[j * WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MAX) ? w : w + WEIGHT_BITS'(1);
      end else begin
        mem_wdata[j * WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MIN) ? w : w - WEIGHT_BITS'(1);
      end
    end
  end

  // Trained bias
  always_comb begin
    if (taken_q) begin
      bias_wdata = (bias_q == W_MAX) ? bias_q : bias_q + WEIGHT_BITS'(1);
    end else begin
      bias_wdata = (bias_q == W_MIN) ? bias_q : bias_q - WEIGHT_BITS'(1);
    end
  end

  // Decision on the finished sum
  assign acc_ext  = EW'(acc);
  assign thr_ext  = signed'(EW'(thr));
  assign in_band  = (acc_ext <= thr_ext) && (acc_ext >= -thr_ext);
  assign pred_now = !acc[SW-1];

  assign stat.reduce_last = (cnt == CNT_W'(pbp_pkg::REDUCE_STEPS - 1));
  assign stat.pass_last   = cnt_pass_last;
  assign stat.train_now   = (req_q == pbp_pkg::REQ_UPDATE) && ((pred_now != taken_q) || in_band);
  assign stat.out_free    = !out_valid || out_ready;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q   <= req_type;
      addr_q  <= pc;
      taken_q <= taken;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      cnt <= '0;
    end else if (cmd.reduce) begin
      cnt <= stat.reduce_last ? '0 : cnt + CNT_W'(1);
    end else if (cmd.sum_pass || cmd.train_pass) begin
      cnt <= cnt_pass_last ? '0 : cnt + CNT_W'(1);
    end
  end

  // Row quotient
  always_ff @(posedge clk) begin
    if (cmd.reduce && !stat.reduce_last) begin
      quot <= quot_next;
    end
  end

  // Row remainder
  always_ff @(posedge clk) begin
    if (cmd.reduce && stat.reduce_last) begin
      row <= row_next;
    end
  end

  // Accumulate bias and weights
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= '0;
    end else if (cmd.sum_pass && cnt != '0 && !cnt_pass_last) begin
      acc <= acc + word_sum + ((cnt == CNT_W'(1)) ? SW'(bias_val) : '0);
    end else if (cmd.sum_pass && cnt_pass_last) begin
      acc <= acc + word_sum + ((cnt == CNT_W'(1)) ? SW'(bias_val) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_pass && cnt == CNT_W'(1)) begin
      bias_q <= bias_val;
    end
  end

  // Hold the decision
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      train_q <= stat.train_now;
      pred_q  <= pred_now;
    end
  end

  // Mark a row trained once all its words are written
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.train_pass && cnt_pass_last) begin
      row_valid[row] <= 1'b1;
    end
  end

  // Global history: shift in the outcome after an update
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (cmd.finish && req_q == pbp_pkg::REQ_UPDATE) begin
      hist <= GHR_BITS'({hist, taken_q});
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      predict_taken  <= pred_q;
      perceptron_sum <= signed'(acc_ext[pbp_pkg::SUM_OUT_W-1:0]);
      trained        <= train_q;
    end
  end

endmodule

[rtl/core/perceptron_branch_predictor_unit.sv]
// Channel   Handshake               Payload
// in        in_valid / in_ready     req_type, pc, taken
// out       out_valid / out_ready   predict_taken, perceptron_sum, trained
// cfg       cfg_we (no wait)        cfg_wdata (train threshold)
//
// One item at a time. Each row holds ceil(GHR_BITS/8) weight words. An item
// passes through the row index (a reciprocal multiply, then a remainder step),
// the sum pass, the decision, the train pass when it trains, and the result. The
// weight memory moves one 8-weight word per cycle in the sum pass and again in
// the train pass. Reset is synchronous and takes effect at once: per-row valid
// bits stand in for cleared weights, so there is no clearing pass. A result
// that is not taken holds the block in its last step; a new item is still
// accepted while an older result waits.
module perceptron_branch_predictor_unit #(
  parameter int GHR_BITS        = 32,
  parameter int NUM_PERCEPTRONS = 64,
  parameter int WEIGHT_BITS     = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [pbp_pkg::ADDR_W-1:0]           pc,
  input  logic                                 taken,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 predict_taken,
  output logic signed [pbp_pkg::SUM_OUT_W-1:0] perceptron_sum,
  output logic                                 trained,
  input  logic                                 cfg_we,
  input  logic [pbp_pkg::THR_W-1:0]            cfg_wdata
);

  localparam logic [pbp_pkg::THR_W-1:0] THR_RESET =
    pbp_pkg::THR_W'((193 * GHR_BITS) / 100 + 14);

  pbp_pkg::dp_cmd_t  cmd;
  pbp_pkg::dp_stat_t stat;

  pbp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  pbp_dp #(
    .GHR_BITS       (GHR_BITS),
    .NUM_PERCEPTRONS(NUM_PERCEPTRONS),
    .WEIGHT_BITS    (WEIGHT_BITS),
    .THR_RESET      (THR_RESET)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .pc            (pc),
    .taken         (taken),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .predict_taken (predict_taken),
    .perceptron_sum(perceptron_sum),
    .trained       (trained)
  );

  // Only one datapath step at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");

  // An accepted item closes the input until it is done
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open while an item is in work");

  // A result is loaded only when the output register is free
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result overwrites a waiting result");

  // No train pass without a training decision
  a_train_gate: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && !stat.train_now) |=> !cmd.train_pass)
    else $error("train pass without a training decision");

endmodule
